// ===== design/tsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared widths, latencies, unit codes and tables for the triangle solver.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int SQ_W       = 50;
    localparam int SIDE_W     = 25;
    localparam int ANGLE_W    = 24;
    localparam int UNIT_W     = 2;

    localparam int SIDE_RAD_W = 50;
    localparam int SIN_RAD_W  = 62;
    localparam int SIN_ROOT_W = SIN_RAD_W / 2;

    localparam int DIV_STEPS    = 30;
    localparam int CORDIC_STEPS = 30;

    localparam int ANGLE_LAT = 9 + DIV_STEPS + SIN_ROOT_W + CORDIC_STEPS;
    localparam int SIDE_LAT  = 3 + SIDE_RAD_W / 2 + 1;
    localparam int TOTAL_LAT = SIDE_LAT + ANGLE_LAT + 1;

    localparam logic [UNIT_W-1:0] UNIT_RAD  = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_DEG  = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_GRAD = 2'd2;

    localparam logic [31:0] K_RAD  = 32'd52707179;
    localparam logic [31:0] K_DEG  = 32'd3019898880;
    localparam logic [31:0] K_GRAD = 32'd3355443200;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 24'd13107200;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1
    };

endpackage

// ===== design/triangle_sides_and_angles_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_sides_and_angles_unit
// Side lengths and interior angles of a triangle given by three vertices.
// ----------------------------------------------------------------------------
// Start to done runs through the side and sine square root pipelines (one bit a
// stage), the cosine divider and the CORDIC stages.
// Throughput: one item per cycle; busy stays low and done is a one-cycle strobe.
// Reset: rst_n clears all valid bits and sets unit_reg to radians.
module triangle_sides_and_angles_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsa_pkg::UNIT_W-1:0]    cfg_data,
    input  logic signed [tsa_pkg::COORD_W-1:0] ax,
    input  logic signed [tsa_pkg::COORD_W-1:0] ay,
    input  logic signed [tsa_pkg::COORD_W-1:0] bx,
    input  logic signed [tsa_pkg::COORD_W-1:0] by_coord,
    input  logic signed [tsa_pkg::COORD_W-1:0] cx,
    input  logic signed [tsa_pkg::COORD_W-1:0] cy,
    output logic                          done,
    output logic [tsa_pkg::SIDE_W-1:0]    side_ab,
    output logic [tsa_pkg::SIDE_W-1:0]    side_bc,
    output logic [tsa_pkg::SIDE_W-1:0]    side_ac,
    output logic [tsa_pkg::ANGLE_W-1:0]   angle_cab,
    output logic [tsa_pkg::ANGLE_W-1:0]   angle_abc,
    output logic [tsa_pkg::ANGLE_W-1:0]   angle_bca,
    output logic                          degenerate
);

    localparam int DW   = tsa_pkg::DIFF_W;
    localparam int SW   = tsa_pkg::SIDE_W;
    localparam int AW   = tsa_pkg::ANGLE_W;
    localparam int ALAT = tsa_pkg::ANGLE_LAT;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [tsa_pkg::UNIT_W-1:0] unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= tsa_pkg::UNIT_RAD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unit_reg <= cfg_data;
        end
    end

    // coordinate differences
    logic                 vd_reg;
    logic signed [DW-1:0] abx_reg, aby_reg, bcx_reg, bcy_reg, acx_reg, acy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
        end
        else
        begin
            vd_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        abx_reg <= DW'(ax) - DW'(bx);
        aby_reg <= DW'(ay) - DW'(by_coord);
        bcx_reg <= DW'(bx) - DW'(cx);
        bcy_reg <= DW'(by_coord) - DW'(cy);
        acx_reg <= DW'(ax) - DW'(cx);
        acy_reg <= DW'(ay) - DW'(cy);
    end

    // squares
    logic                          vs_reg;
    logic [tsa_pkg::SQ_W-1:0]      sabx_reg, saby_reg, sbcx_reg, sbcy_reg, sacx_reg, sacy_reg;
    logic signed [tsa_pkg::SQ_W-1:0] pabx, paby, pbcx, pbcy, pacx, pacy;

    assign pabx = abx_reg * abx_reg;
    assign paby = aby_reg * aby_reg;
    assign pbcx = bcx_reg * bcx_reg;
    assign pbcy = bcy_reg * bcy_reg;
    assign pacx = acx_reg * acx_reg;
    assign pacy = acy_reg * acy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= 1'b0;
        end
        else
        begin
            vs_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sabx_reg <= pabx;
        saby_reg <= paby;
        sbcx_reg <= pbcx;
        sbcy_reg <= pbcy;
        sacx_reg <= pacx;
        sacy_reg <= pacy;
    end

    // squared distances
    logic                           vq_reg;
    logic [tsa_pkg::SIDE_RAD_W-1:0] dab_reg, dbc_reg, dac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
        end
        else
        begin
            vq_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dab_reg <= sabx_reg + saby_reg;
        dbc_reg <= sbcx_reg + sbcy_reg;
        dac_reg <= sacx_reg + sacy_reg;
    end

    logic          root_valid;
    logic [SW-1:0] root_ab, root_bc, root_ac;

    tsa_isqrt #(
        .RAD_W  (tsa_pkg::SIDE_RAD_W),
        .ROOT_W (tsa_pkg::SIDE_RAD_W / 2)
    ) u_sqrt_ab (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vq_reg),
        .radicand  (dab_reg),
        .out_valid (root_valid),
        .root      (root_ab)
    );

    tsa_isqrt #(
        .RAD_W  (tsa_pkg::SIDE_RAD_W),
        .ROOT_W (tsa_pkg::SIDE_RAD_W / 2)
    ) u_sqrt_bc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vq_reg),
        .radicand  (dbc_reg),
        .out_valid (),
        .root      (root_bc)
    );

    tsa_isqrt #(
        .RAD_W  (tsa_pkg::SIDE_RAD_W),
        .ROOT_W (tsa_pkg::SIDE_RAD_W / 2)
    ) u_sqrt_ac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vq_reg),
        .radicand  (dac_reg),
        .out_valid (),
        .root      (root_ac)
    );

    // sides and degenerate flag
    logic          vt_reg;
    logic [SW-1:0] ab_reg, bc_reg, ac_reg;
    logic          dg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg <= 1'b0;
        end
        else
        begin
            vt_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ab_reg <= root_ab;
        bc_reg <= root_bc;
        ac_reg <= root_ac;
        dg_reg <= (root_ab == '0) || (root_bc == '0) || (root_ac == '0);
    end

    logic          ang_valid;
    logic [AW-1:0] ang_a, ang_b, ang_c;

    tsa_angle u_angle_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vt_reg),
        .side_p    (ab_reg),
        .side_q    (ac_reg),
        .side_o    (bc_reg),
        .unit      (unit_reg),
        .out_valid (ang_valid),
        .angle     (ang_a)
    );

    tsa_angle u_angle_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vt_reg),
        .side_p    (ab_reg),
        .side_q    (bc_reg),
        .side_o    (ac_reg),
        .unit      (unit_reg),
        .out_valid (),
        .angle     (ang_b)
    );

    tsa_angle u_angle_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vt_reg),
        .side_p    (bc_reg),
        .side_q    (ac_reg),
        .side_o    (ab_reg),
        .unit      (unit_reg),
        .out_valid (),
        .angle     (ang_c)
    );

    // sides wait alongside the angle pipeline
    logic [SW-1:0] dly_ab_reg [ALAT];
    logic [SW-1:0] dly_bc_reg [ALAT];
    logic [SW-1:0] dly_ac_reg [ALAT];
    logic          dly_dg_reg [ALAT];

    always_ff @(posedge clk)
    begin
        dly_ab_reg[0] <= ab_reg;
        dly_bc_reg[0] <= bc_reg;
        dly_ac_reg[0] <= ac_reg;
        dly_dg_reg[0] <= dg_reg;
        for (int i = 1; i < ALAT; i++)
        begin
            dly_ab_reg[i] <= dly_ab_reg[i-1];
            dly_bc_reg[i] <= dly_bc_reg[i-1];
            dly_ac_reg[i] <= dly_ac_reg[i-1];
            dly_dg_reg[i] <= dly_dg_reg[i-1];
        end
    end

    // result register
    logic          done_reg;
    logic [SW-1:0] out_ab_reg, out_bc_reg, out_ac_reg;
    logic [AW-1:0] out_a_reg, out_b_reg, out_c_reg;
    logic          out_dg_reg;
    logic          dg_last;

    assign dg_last = dly_dg_reg[ALAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ang_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ab_reg <= dly_ab_reg[ALAT-1];
        out_bc_reg <= dly_bc_reg[ALAT-1];
        out_ac_reg <= dly_ac_reg[ALAT-1];
        out_dg_reg <= dg_last;
        out_a_reg  <= dg_last ? '0 : ang_a;
        out_b_reg  <= dg_last ? '0 : ang_b;
        out_c_reg  <= dg_last ? '0 : ang_c;
    end

    assign done       = done_reg;
    assign side_ab    = out_ab_reg;
    assign side_bc    = out_bc_reg;
    assign side_ac    = out_ac_reg;
    assign angle_cab  = out_a_reg;
    assign angle_abc  = out_b_reg;
    assign angle_bca  = out_c_reg;
    assign degenerate = out_dg_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(tsa_pkg::TOTAL_LAT) done)
        else $error("item did not complete at fixed latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, tsa_pkg::TOTAL_LAT))
        else $error("done without a matching start");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (angle_cab == '0 && angle_abc == '0 && angle_bca == '0))
        else $error("degenerate item with nonzero angle");

    a_degen_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (degenerate == (side_ab == '0 || side_bc == '0 || side_ac == '0)))
        else $error("degenerate flag does not match sides");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_cab <= tsa_pkg::ANGLE_MAX && angle_abc <= tsa_pkg::ANGLE_MAX
                  && angle_bca <= tsa_pkg::ANGLE_MAX))
        else $error("angle beyond a half turn");

endmodule

// ===== design/tsa_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_isqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module tsa_isqrt #(
    parameter int RAD_W  = tsa_pkg::SIDE_RAD_W,
    parameter int ROOT_W = RAD_W / 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  radicand,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic              valid_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic              valid_cur;
        logic [RAD_W-1:0]  rad_cur;
        logic [REM_W-1:0]  rem_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W+1:0]  rem_diff;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (s == 0) begin : g_first
            assign valid_cur = in_valid;
            assign rad_cur   = radicand;
            assign rem_cur   = '0;
            assign root_cur  = '0;
        end
        else begin : g_rest
            assign valid_cur = valid_reg[s-1];
            assign rad_cur   = rad_reg[s-1];
            assign rem_cur   = rem_reg[s-1];
            assign root_cur  = root_reg[s-1];
        end

        assign rem_sh    = {rem_cur, rad_cur[RAD_W-1 -: 2]};
        assign trial     = {2'b00, root_cur, 2'b01};
        assign ge        = rem_sh >= trial;
        assign rem_diff  = ge ? (rem_sh - trial) : rem_sh;
        assign rem_next  = rem_diff[REM_W-1:0];
        assign root_next = {root_cur[ROOT_W-2:0], ge};
        assign rad_next  = {rad_cur[RAD_W-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[s]  <= rad_next;
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];

endmodule

// ===== design/tsa_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_angle
// Angle opposite side o: cosine by long division, sine by square root,
// arc cosine by CORDIC vectoring, then scaling to the selected unit.
// ----------------------------------------------------------------------------
module tsa_angle (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [tsa_pkg::SIDE_W-1:0]    side_p,
    input  logic [tsa_pkg::SIDE_W-1:0]    side_q,
    input  logic [tsa_pkg::SIDE_W-1:0]    side_o,
    input  logic [tsa_pkg::UNIT_W-1:0]    unit,
    output logic                          out_valid,
    output logic [tsa_pkg::ANGLE_W-1:0]   angle
);

    localparam int NSTEP = tsa_pkg::DIV_STEPS;
    localparam int CSTEP = tsa_pkg::CORDIC_STEPS;
    localparam int SROOT = tsa_pkg::SIN_ROOT_W;
    localparam int XY_W  = 33;
    localparam int Z_W   = 34;

    // multiply stage
    logic        v0_reg;
    logic [49:0] pp_reg, qq_reg, oo_reg, pq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= side_p * side_p;
        qq_reg <= side_q * side_q;
        oo_reg <= side_o * side_o;
        pq_reg <= side_p * side_q;
    end

    // numerator and denominator
    logic               v1_reg;
    logic signed [51:0] num_reg;
    logic [50:0]        den1_reg;
    logic signed [51:0] num_next;

    assign num_next = $signed({2'b00, pp_reg}) + $signed({2'b00, qq_reg})
                    - $signed({2'b00, oo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den1_reg <= {pq_reg, 1'b0};
    end

    // magnitude and saturation
    logic        v2_reg;
    logic [50:0] mag_reg;
    logic [50:0] den2_reg;
    logic        neg2_reg;
    logic        sat2_reg;
    logic [51:0] mag_full;

    assign mag_full = num_reg[51] ? 52'(-num_reg) : 52'(num_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_full[50:0];
        den2_reg <= den1_reg;
        neg2_reg <= num_reg[51];
        sat2_reg <= mag_full[50:0] >= den1_reg;
    end

    // restoring division, one quotient bit per stage
    logic             dv_valid_reg [NSTEP];
    logic [50:0]      dv_r_reg     [NSTEP];
    logic [NSTEP-1:0] dv_q_reg     [NSTEP];
    logic [50:0]      dv_den_reg   [NSTEP];
    logic             dv_neg_reg   [NSTEP];
    logic             dv_sat_reg   [NSTEP];

    for (genvar s = 0; s < NSTEP; s++) begin : g_div
        logic             v_cur;
        logic [50:0]      r_cur;
        logic [NSTEP-1:0] q_cur;
        logic [50:0]      den_cur;
        logic             neg_cur;
        logic             sat_cur;
        logic [51:0]      r2;
        logic             ge;
        logic [51:0]      r_sub;

        if (s == 0) begin : g_first
            assign v_cur   = v2_reg;
            assign r_cur   = mag_reg;
            assign q_cur   = '0;
            assign den_cur = den2_reg;
            assign neg_cur = neg2_reg;
            assign sat_cur = sat2_reg;
        end
        else begin : g_rest
            assign v_cur   = dv_valid_reg[s-1];
            assign r_cur   = dv_r_reg[s-1];
            assign q_cur   = dv_q_reg[s-1];
            assign den_cur = dv_den_reg[s-1];
            assign neg_cur = dv_neg_reg[s-1];
            assign sat_cur = dv_sat_reg[s-1];
        end

        assign r2    = {r_cur, 1'b0};
        assign ge    = r2 >= {1'b0, den_cur};
        assign r_sub = ge ? (r2 - {1'b0, den_cur}) : r2;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[s] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[s] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_r_reg[s]   <= r_sub[50:0];
            dv_q_reg[s]   <= {q_cur[NSTEP-2:0], ge};
            dv_den_reg[s] <= den_cur;
            dv_neg_reg[s] <= neg_cur;
            dv_sat_reg[s] <= sat_cur;
        end
    end

    // cosine square
    logic        vsq_reg;
    logic [30:0] cm_sq_reg;
    logic        neg_sq_reg;
    logic [61:0] cmsq_reg;
    logic [30:0] cm_next;

    assign cm_next = dv_sat_reg[NSTEP-1] ? 31'h4000_0000
                                         : {1'b0, dv_q_reg[NSTEP-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsq_reg <= 1'b0;
        end
        else
        begin
            vsq_reg <= dv_valid_reg[NSTEP-1];
        end
    end

    always_ff @(posedge clk)
    begin
        cm_sq_reg  <= cm_next;
        neg_sq_reg <= dv_neg_reg[NSTEP-1];
        cmsq_reg   <= cm_next * cm_next;
    end

    // sine radicand
    logic        vrad_reg;
    logic [30:0] cm_rad_reg;
    logic        neg_rad_reg;
    logic [61:0] rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vrad_reg <= 1'b0;
        end
        else
        begin
            vrad_reg <= vsq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cm_rad_reg  <= cm_sq_reg;
        neg_rad_reg <= neg_sq_reg;
        rad_reg     <= 62'h1000_0000_0000_0000 - cmsq_reg;
    end

    logic             sin_valid;
    logic [SROOT-1:0] sin_root;

    tsa_isqrt #(
        .RAD_W  (tsa_pkg::SIN_RAD_W),
        .ROOT_W (SROOT)
    ) u_sin_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vrad_reg),
        .radicand  (rad_reg),
        .out_valid (sin_valid),
        .root      (sin_root)
    );

    logic [30:0] cmd_reg  [SROOT];
    logic        negd_reg [SROOT];

    always_ff @(posedge clk)
    begin
        cmd_reg[0]  <= cm_rad_reg;
        negd_reg[0] <= neg_rad_reg;
        for (int i = 1; i < SROOT; i++)
        begin
            cmd_reg[i]  <= cmd_reg[i-1];
            negd_reg[i] <= negd_reg[i-1];
        end
    end

    // CORDIC setup: negative cosine is turned by a quarter turn first
    logic                  vin_reg;
    logic signed [XY_W-1:0] x0_reg, y0_reg;
    logic signed [Z_W-1:0]  z0_reg;
    logic                  swap;
    logic signed [XY_W-1:0] cm_s, sin_s;

    assign cm_s  = $signed({2'b00, cmd_reg[SROOT-1]});
    assign sin_s = $signed({{(XY_W-SROOT){1'b0}}, sin_root});
    assign swap  = negd_reg[SROOT-1] && (cmd_reg[SROOT-1] != 31'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin_reg <= 1'b0;
        end
        else
        begin
            vin_reg <= sin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= swap ? sin_s : cm_s;
        y0_reg <= swap ? cm_s : sin_s;
        z0_reg <= swap ? $signed(34'h0_4000_0000) : '0;
    end

    logic                   cr_valid_reg [CSTEP];
    logic signed [XY_W-1:0] cr_x_reg     [CSTEP];
    logic signed [XY_W-1:0] cr_y_reg     [CSTEP];
    logic signed [Z_W-1:0]  cr_z_reg     [CSTEP];

    for (genvar s = 0; s < CSTEP; s++) begin : g_cordic
        logic                   v_cur;
        logic signed [XY_W-1:0] x_cur, y_cur, dx, dy;
        logic signed [Z_W-1:0]  z_cur, at;

        if (s == 0) begin : g_first
            assign v_cur = vin_reg;
            assign x_cur = x0_reg;
            assign y_cur = y0_reg;
            assign z_cur = z0_reg;
        end
        else begin : g_rest
            assign v_cur = cr_valid_reg[s-1];
            assign x_cur = cr_x_reg[s-1];
            assign y_cur = cr_y_reg[s-1];
            assign z_cur = cr_z_reg[s-1];
        end

        assign dx = y_cur >>> s;
        assign dy = x_cur >>> s;
        assign at = $signed({2'b00, tsa_pkg::ATAN_TAB[s]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cr_valid_reg[s] <= 1'b0;
            end
            else
            begin
                cr_valid_reg[s] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (!y_cur[XY_W-1])
            begin
                cr_x_reg[s] <= x_cur + dx;
                cr_y_reg[s] <= y_cur - dy;
                cr_z_reg[s] <= z_cur + at;
            end
            else
            begin
                cr_x_reg[s] <= x_cur - dx;
                cr_y_reg[s] <= y_cur + dy;
                cr_z_reg[s] <= z_cur - at;
            end
        end
    end

    // clamp to a half turn
    logic                  vcl_reg;
    logic [31:0]           zcl_reg;
    logic signed [Z_W-1:0] z_last;

    assign z_last = cr_z_reg[CSTEP-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcl_reg <= 1'b0;
        end
        else
        begin
            vcl_reg <= cr_valid_reg[CSTEP-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (z_last[Z_W-1])
        begin
            zcl_reg <= 32'd0;
        end
        else if (z_last > $signed(34'h0_8000_0000))
        begin
            zcl_reg <= 32'h8000_0000;
        end
        else
        begin
            zcl_reg <= z_last[31:0];
        end
    end

    // unit scaling
    logic        vsc_reg;
    logic [63:0] prod_reg;
    logic [31:0] k_sel;

    always_comb
    begin
        case (unit)
            tsa_pkg::UNIT_DEG:  k_sel = tsa_pkg::K_DEG;
            tsa_pkg::UNIT_GRAD: k_sel = tsa_pkg::K_GRAD;
            default:            k_sel = tsa_pkg::K_RAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsc_reg <= 1'b0;
        end
        else
        begin
            vsc_reg <= vcl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= zcl_reg * k_sel;
    end

    // round
    logic                        vout_reg;
    logic [tsa_pkg::ANGLE_W-1:0] angle_reg;
    logic [63:0]                 rounded;

    assign rounded = prod_reg + 64'h0000_0040_0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else
        begin
            vout_reg <= vsc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= rounded[62:39];
    end

    assign out_valid = vout_reg;
    assign angle     = angle_reg;

endmodule
